>>> sv/osm_pkg.sv
// ----------------------------------------------------------------------------
// osm_pkg
// Shared constants, codes and types of the order-statistic multiset.
// ----------------------------------------------------------------------------
package osm_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OPCODE_W = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 3'd0,
        OP_ERASE  = 3'd1,
        OP_RANK   = 3'd2,
        OP_KTH    = 3'd3,
        OP_PRED   = 3'd4,
        OP_SUCC   = 3'd5
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_MISSING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_DECIDE,
        ST_FETCHED,
        ST_SHIFT,
        ST_RESP
    } t_state;

endpackage

>>> sv/osm_if.sv
// ----------------------------------------------------------------------------
// osm_if
// Valid/ready channels of the order-statistic multiset: request and response.
// ----------------------------------------------------------------------------
interface osm_req_if import osm_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [DATA_W-1:0]   operand;

    modport source (output valid, output opcode, output operand, input ready);
    modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface osm_rsp_if import osm_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   answer;
    logic [STATUS_W-1:0]        status;
    logic [OCC_W-1:0]           occupancy;

    modport source (output valid, output answer, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input answer, input status, input occupancy,
                    output ready);
endinterface

>>> sv/order_statistic_multiset_top.sv
// ----------------------------------------------------------------------------
// order_statistic_multiset_top
// Sorted multiset of signed values with insert, erase, rank, kth smallest,
// predecessor and successor requests; one response per request.
// ----------------------------------------------------------------------------
// Sequence: a binary search over the stored values alternates SEARCH and COMPARE;
// rank then answers, predecessor and successor fetch the found entry, kth skips the
// search; insert, and erase once the value is found, shift later entries one slot apiece.
// Throughput: one request at a time; the next is taken the cycle after the response.
// Reset: clears the count and the sequencer; store contents stay undefined and
// need no clearing pass, since no entry at or above the count is ever used.
// ----------------------------------------------------------------------------
module order_statistic_multiset_top import osm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    osm_req_if.sink   i_req,
    osm_rsp_if.source o_rsp
);

    t_state r_state, n_state;

    logic [OPCODE_W-1:0]      r_op, n_op;
    logic signed [DATA_W-1:0] r_x, n_x;
    logic                     r_or_eq, n_or_eq;
    logic [CNT_W-1:0]         r_lo, n_lo;
    logic [CNT_W-1:0]         r_hi, n_hi;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_ptr, n_ptr;
    logic [CNT_W-1:0]         r_left, n_left;
    logic                     r_rdv, n_rdv;
    logic [ADDR_W-1:0]        r_rda, n_rda;
    logic signed [DATA_W-1:0] r_answer, n_answer;
    t_status                  r_status, n_status;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    logic                     req_fire;
    logic                     rsp_fire;
    logic [CNT_W:0]           mid_sum;
    logic [CNT_W-1:0]         mid;
    logic                     cmp_lt;
    logic                     cmp_eq;
    logic                     go_right;
    logic                     is_ins;
    logic                     shift_done;
    logic                     lo_found;
    logic [CNT_W-1:0]         pos;

    osm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign req_fire = i_req.valid && i_req.ready;
    assign rsp_fire = o_rsp.valid && o_rsp.ready;

    assign i_req.ready     = (r_state == ST_IDLE);
    assign o_rsp.valid     = (r_state == ST_RESP);
    assign o_rsp.answer    = r_answer;
    assign o_rsp.status    = r_status;
    assign o_rsp.occupancy = OCC_W'(r_count);

    // shared compare unit: stored value against the request operand
    assign cmp_lt   = $signed(ram_rdata) < r_x;
    assign cmp_eq   = ram_rdata == r_x;
    assign go_right = r_or_eq ? (cmp_lt || cmp_eq) : cmp_lt;

    assign mid_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid        = mid_sum[CNT_W:1];
    assign is_ins     = (r_op == OP_INSERT);
    assign shift_done = (r_left == '0) && !r_rdv;
    assign lo_found   = (r_lo < r_count);

    // 1-based position that a value query reads, clamped to the stored range
    always_comb begin
        pos = '0;
        unique case (r_op)
            OP_KTH: begin
                if (r_x[DATA_W-1] || (r_x == '0)) begin
                    pos = CNT_W'(1);
                end else if ($unsigned(r_x) > DATA_W'(r_count)) begin
                    pos = r_count;
                end else begin
                    pos = r_x[CNT_W-1:0];
                end
            end
            OP_PRED: pos = (r_lo == '0) ? CNT_W'(1) : r_lo;
            OP_SUCC: pos = lo_found ? r_lo + CNT_W'(1) : r_count;
            default: pos = r_lo + CNT_W'(1);
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    unique case (i_req.opcode)
                        OP_INSERT: n_state = (r_count >= CNT_W'(CAPACITY)) ? ST_RESP
                                                                           : ST_SEARCH;
                        OP_ERASE,
                        OP_PRED,
                        OP_SUCC:   n_state = (r_count == '0) ? ST_RESP : ST_SEARCH;
                        OP_RANK:   n_state = ST_SEARCH;
                        OP_KTH:    n_state = (r_count == '0) ? ST_RESP : ST_DECIDE;
                        default:   n_state = ST_RESP;
                    endcase
                end
            end
            ST_SEARCH:  n_state = (r_lo < r_hi) ? ST_COMPARE : ST_DECIDE;
            ST_COMPARE: n_state = ST_SEARCH;
            ST_DECIDE: begin
                unique case (r_op)
                    OP_INSERT: n_state = ST_SHIFT;
                    OP_ERASE:  n_state = lo_found ? ST_FETCHED : ST_RESP;
                    OP_RANK:   n_state = ST_RESP;
                    default:   n_state = ST_FETCHED;
                endcase
            end
            ST_FETCHED: begin
                n_state = ((r_op == OP_ERASE) && cmp_eq) ? ST_SHIFT : ST_RESP;
            end
            ST_SHIFT:   n_state = shift_done ? ST_RESP : ST_SHIFT;
            ST_RESP:    n_state = rsp_fire ? ST_IDLE : ST_RESP;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_op      = r_op;
        n_x       = r_x;
        n_or_eq   = r_or_eq;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_left    = r_left;
        n_rdv     = 1'b0;
        n_rda     = r_rda;
        n_answer  = r_answer;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_rda;
        ram_wdata = ram_rdata;
        ram_raddr = mid[ADDR_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_op     = i_req.opcode;
                    n_x      = i_req.operand;
                    n_or_eq  = (i_req.opcode == OP_INSERT) || (i_req.opcode == OP_SUCC);
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_answer = '0;
                    n_status = STAT_OK;
                    unique case (i_req.opcode)
                        OP_INSERT: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_status = STAT_FULL;
                            end
                        end
                        OP_ERASE, OP_KTH, OP_PRED, OP_SUCC: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEARCH: begin
                ram_raddr = mid[ADDR_W-1:0];
            end
            ST_COMPARE: begin
                if (go_right) begin
                    n_lo = mid + CNT_W'(1);
                end else begin
                    n_hi = mid;
                end
            end
            ST_DECIDE: begin
                ram_raddr = ADDR_W'(pos - CNT_W'(1));
                unique case (r_op)
                    OP_INSERT: begin
                        n_left = r_count - r_lo;
                        n_ptr  = r_count - CNT_W'(1);
                    end
                    OP_ERASE: begin
                        ram_raddr = r_lo[ADDR_W-1:0];
                        if (!lo_found) begin
                            n_status = STAT_MISSING;
                        end
                    end
                    OP_RANK: begin
                        n_answer = DATA_W'(r_lo) + DATA_W'(1);
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end
                    end
                    default: ;
                endcase
            end
            ST_FETCHED: begin
                if (r_op == OP_ERASE) begin
                    if (cmp_eq) begin
                        n_left = r_count - r_lo - CNT_W'(1);
                        n_ptr  = r_lo + CNT_W'(1);
                    end else begin
                        n_status = STAT_MISSING;
                    end
                end else begin
                    n_answer = ram_rdata;
                end
            end
            ST_SHIFT: begin
                // move the entry read last cycle one slot up or down
                if (r_rdv) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    ram_waddr = is_ins ? r_rda + ADDR_W'(1) : r_rda - ADDR_W'(1);
                end
                if (r_left != '0) begin
                    ram_raddr = r_ptr[ADDR_W-1:0];
                    n_rdv     = 1'b1;
                    n_rda     = r_ptr[ADDR_W-1:0];
                    n_left    = r_left - CNT_W'(1);
                    n_ptr     = is_ins ? r_ptr - CNT_W'(1) : r_ptr + CNT_W'(1);
                end
                if (shift_done) begin
                    if (is_ins) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_lo[ADDR_W-1:0];
                        ram_wdata = r_x;
                        n_count   = r_count + CNT_W'(1);
                    end else begin
                        n_count   = r_count - CNT_W'(1);
                    end
                end
            end
            ST_RESP: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_rdv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rdv   <= n_rdv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_x      <= n_x;
        r_or_eq  <= n_or_eq;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_rda    <= n_rda;
        r_answer <= n_answer;
        r_status <= n_status;
    end

endmodule

>>> sv/osm_ram.sv
// ----------------------------------------------------------------------------
// osm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module osm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
